// ----- design/lkc_pkg.sv -----
`default_nettype none

package lkc_pkg;

    // Geometry
    localparam int ENTRIES    = 128;
    localparam int HIT_W      = 32;
    localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int KEY_W      = 64;
    localparam int DATA_W     = 64;
    localparam int SLOT_OUT_W = 7;
    localparam int BONUS_W    = 8;

    localparam logic [BONUS_W-1:0] BONUS_RESET = BONUS_W'(5);
    localparam logic [HIT_W-1:0]   INSERT_HITS = HIT_W'(1);

    // Opcodes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic                     opcode;
        logic signed [KEY_W-1:0]  search_key;
        logic                     any_key;
        logic        [DATA_W-1:0] entry_data;
    } t_in;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [DATA_W-1:0]     found_data;
        logic                  evicted;
        logic [DATA_W-1:0]     evicted_data;
    } t_out;

    // Request fields broadcast to every cell while a scan runs
    typedef struct packed {
        logic             opcode;
        logic             any_key;
        logic [KEY_W-1:0] key;
    } t_req;

    // Scan token handed from cell to cell. For a lookup, found marks the
    // first match; for an insert it marks that a minimum has been seeded.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [HIT_W-1:0]  hits;
        logic [SLOT_W-1:0] idx;
        logic [DATA_W-1:0] data;
    } t_token;

    // Slot write broadcast
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
        logic [HIT_W-1:0]  hits;
    } t_wr;

endpackage

`default_nettype wire

// ----- design/lkc_cell.sv -----
`default_nettype none

module lkc_cell
    import lkc_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [SLOT_W-1:0] i_cell_idx,
    input  wire  [CNT_W-1:0]  i_count,
    input  t_req              i_req,
    input  t_wr               i_wr,
    input  t_token            i_tok,
    output t_token            o_tok
);

    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_data;
    logic [HIT_W-1:0]  r_hits;
    t_token            r_tok;
    t_token            n_tok;
    logic              filled;
    logic              match;
    logic              bump;

    always_comb begin
        filled = CNT_W'(i_cell_idx) < i_count;
        match  = filled && (i_req.any_key || (r_key == i_req.key));
        n_tok  = i_tok;
        bump   = 1'b0;
        if (i_tok.valid) begin
            if (i_req.opcode == OP_LOOKUP) begin
                // first match claims the token
                if (!i_tok.found && match) begin
                    n_tok.found = 1'b1;
                    n_tok.idx   = i_cell_idx;
                    n_tok.data  = r_data;
                    bump        = 1'b1;
                end
            end else begin
                // strict less-than keeps the lowest index among equal minima
                if (filled && (!i_tok.found || (r_hits < i_tok.hits))) begin
                    n_tok.found = 1'b1;
                    n_tok.hits  = r_hits;
                    n_tok.idx   = i_cell_idx;
                    n_tok.data  = r_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.found <= n_tok.found;
        r_tok.hits  <= n_tok.hits;
        r_tok.idx   <= n_tok.idx;
        r_tok.data  <= n_tok.data;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_cell_idx)) begin
            r_key  <= i_wr.key;
            r_data <= i_wr.data;
            r_hits <= i_wr.hits;
        end else if (bump && (r_hits != {HIT_W{1'b1}})) begin
            r_hits <= r_hits + HIT_W'(1);
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ----- design/lfu_key_cache.sv -----
`default_nettype none

// Fully associative key cache with least-frequently-used replacement, built as
// a chain of ENTRIES slot cells. One transaction is in work at a time. A lookup
// or an insert into a full cache launches a scan token that moves one cell per
// cycle along the chain: on a lookup the first filled cell whose key matches
// (or the first filled cell in any-key mode) claims it and bumps its saturating
// hit count; on an insert every cell folds its hit count into a running
// minimum, the lowest index winning ties. When the token leaves the last cell
// the victim slot is rewritten with the new key and payload and a hit count of
// the minimum plus eviction_bonus, saturating. An insert into a cache with free
// slots skips the scan and writes the next free slot with a hit count of one.
// For a scan, the accepted request sets r_launch, the token passes through each cell's
// register in turn and the result goes to r_res, then to the output register; a
// non-full insert goes to r_res directly. A finished result sits in an output register,
// so the next input transaction can be taken while it waits. eviction_bonus is written
// through i_cfg_we / i_cfg_data and resets to 5; the user must write it only while
// the block is idle, which the block itself does not enforce. Slot contents have
// no reset; only slots below the fill count are ever read.
module lfu_key_cache
    import lkc_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  t_in                i_in,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output t_out               o_out,
    input  wire                i_cfg_we,
    input  wire  [BONUS_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [BONUS_W-1:0] r_bonus;
    t_req               r_req;
    logic [DATA_W-1:0]  r_data;
    logic               r_launch;
    t_wr                r_wr;
    t_out               r_res;
    t_out               r_out;
    logic               r_out_valid;

    t_token             w_tok [ENTRIES+1];
    logic [ENTRIES-1:0] w_tok_valid;
    t_token             tok_end;
    logic               in_accept;
    logic               full;
    logic [HIT_W:0]     bonus_sum;
    logic [HIT_W-1:0]   victim_hits;

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign full       = (r_count == CNT_W'(ENTRIES));
    assign tok_end    = w_tok[ENTRIES];

    // Minimum plus bonus, stuck at the top of the counter range on overflow
    always_comb begin
        bonus_sum = {1'b0, tok_end.hits} + (HIT_W + 1)'(r_bonus);
        if (bonus_sum[HIT_W]) begin
            victim_hits = {HIT_W{1'b1}};
        end else begin
            victim_hits = bonus_sum[HIT_W-1:0];
        end
    end

    // Token entering the head of the chain
    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].valid = r_launch;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (SLOT_W'(g)),
            .i_count    (r_count),
            .i_req      (r_req),
            .i_wr       (r_wr),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
        assign w_tok_valid[g] = w_tok[g+1].valid;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bonus <= BONUS_RESET;
        end else if (i_cfg_we) begin
            r_bonus <= i_cfg_data;
        end
    end

    // Sequencer: state, fill count, slot writes, result and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_launch    <= 1'b0;
            r_wr.en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // single-cycle pulses: launch a scan, write a slot
            r_launch <= in_accept && !((i_in.opcode == OP_INSERT) && !full);
            r_wr.en  <= (in_accept && (i_in.opcode == OP_INSERT) && !full) ||
                        ((r_state == ST_SCAN) && tok_end.valid &&
                         (r_req.opcode == OP_INSERT));

            // drop the output once the consumer takes it
            if (r_out_valid && i_out_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_req.opcode  <= i_in.opcode;
                        r_req.any_key <= i_in.any_key;
                        r_req.key     <= $unsigned(i_in.search_key);
                        r_data        <= i_in.entry_data;
                        if ((i_in.opcode == OP_INSERT) && !full) begin
                            // free slot: write it straight away
                            r_wr.idx           <= SLOT_W'(r_count);
                            r_wr.key           <= $unsigned(i_in.search_key);
                            r_wr.data          <= i_in.entry_data;
                            r_wr.hits          <= INSERT_HITS;
                            r_count            <= r_count + CNT_W'(1);
                            r_res.hit          <= 1'b1;
                            r_res.slot_index   <= SLOT_OUT_W'(r_count);
                            r_res.found_data   <= i_in.entry_data;
                            r_res.evicted      <= 1'b0;
                            r_res.evicted_data <= '0;
                            r_state            <= ST_DONE;
                        end else begin
                            r_state  <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (tok_end.valid) begin
                        if (r_req.opcode == OP_LOOKUP) begin
                            r_res.hit          <= tok_end.found;
                            r_res.slot_index   <= tok_end.found ?
                                                  SLOT_OUT_W'(tok_end.idx) : '0;
                            r_res.found_data   <= tok_end.found ? tok_end.data : '0;
                            r_res.evicted      <= 1'b0;
                            r_res.evicted_data <= '0;
                        end else begin
                            // evict the least-used slot
                            r_wr.idx           <= tok_end.idx;
                            r_wr.key           <= r_req.key;
                            r_wr.data          <= r_data;
                            r_wr.hits          <= victim_hits;
                            r_res.hit          <= 1'b1;
                            r_res.slot_index   <= SLOT_OUT_W'(tok_end.idx);
                            r_res.found_data   <= r_data;
                            r_res.evicted      <= 1'b1;
                            r_res.evicted_data <= tok_end.data;
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hand the result over once the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // At most one scan token is ever in the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_tok_valid, r_launch}))
        else $error("more than one scan token in the chain");

    // Taking a new transaction implies no scan is still running
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (w_tok_valid == '0) && !r_launch)
        else $error("input ready while a scan is in flight");

    // The fill count never passes the slot count
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("fill count beyond the number of slots");

    // A slot write never overlaps a scan
    a_wr_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr.en |-> (w_tok_valid == '0) && !r_launch)
        else $error("slot write during a scan");
`endif

endmodule

`default_nettype wire
